FILE: rtl/scic_pkg.sv
// Shared types and constants for the slave clock impulse controller.
// No dependencies; imported by every module of the block.
package scic_pkg;

  localparam int TickW  = 5;
  localparam int SecW   = 6;
  localparam int HoldW  = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [HoldW-1:0] HoldMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TICKS_PER_SECOND   = 2'd0,
    REG_PULSE_WIDTH_TICKS  = 2'd1,
    REG_LONG_PRESS_TICKS   = 2'd2,
    REG_SECONDS_PER_MINUTE = 2'd3
  } cfg_reg_t;

  localparam logic [TickW-1:0] TicksPerSecondRst   = 5'd25;
  localparam logic [TickW-1:0] PulseWidthTicksRst  = 5'd2;
  localparam logic [HoldW-1:0] LongPressTicksRst   = 8'd25;
  localparam logic [SecW-1:0]  SecondsPerMinuteRst = 6'd60;

  typedef struct packed {
    logic [TickW-1:0] ticks_per_second;
    logic [TickW-1:0] pulse_width_ticks;
    logic [HoldW-1:0] long_press_ticks;
    logic [SecW-1:0]  seconds_per_minute;
  } cfg_t;

  typedef struct packed {
    logic drive_a;
    logic drive_b;
    logic second_elapsed;
  } result_t;

endpackage

FILE: rtl/scic_cfg_regs.sv
// Configuration register file of the slave clock impulse controller.
// Depends on scic_pkg for the register indexes and the cfg_t bundle.
module scic_cfg_regs import scic_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second   <= TicksPerSecondRst;
      cfg_r.pulse_width_ticks  <= PulseWidthTicksRst;
      cfg_r.long_press_ticks   <= LongPressTicksRst;
      cfg_r.seconds_per_minute <= SecondsPerMinuteRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICKS_PER_SECOND:   cfg_r.ticks_per_second   <= cfg_wdata[TickW-1:0];
        REG_PULSE_WIDTH_TICKS:  cfg_r.pulse_width_ticks  <= cfg_wdata[TickW-1:0];
        REG_LONG_PRESS_TICKS:   cfg_r.long_press_ticks   <= cfg_wdata[HoldW-1:0];
        REG_SECONDS_PER_MINUTE: cfg_r.seconds_per_minute <= cfg_wdata[SecW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/scic_core.sv
// Tick, second and button state of the slave clock impulse controller.
// Depends on scic_pkg; advances one base tick per step strobe.
module scic_core import scic_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  logic    pressed,
  input  cfg_t    cfg,
  output result_t res
);

  logic [TickW-1:0] tick_r,  tick_nxt;
  logic [SecW-1:0]  sec_r,   sec_nxt;
  logic             tock_r,  tock_nxt;
  logic [1:0]       drv_r,   drv_nxt;
  logic [HoldW-1:0] hold_r,  hold_nxt;
  logic             seen_r,  seen_nxt;
  logic             armed_r, armed_nxt;
  logic             sec_evt;

  always_comb begin
    tick_nxt  = tick_r + 1'b1;
    sec_nxt   = sec_r;
    tock_nxt  = tock_r;
    drv_nxt   = drv_r;
    hold_nxt  = hold_r;
    seen_nxt  = seen_r;
    armed_nxt = armed_r;
    sec_evt   = 1'b0;

    if (tick_nxt == cfg.ticks_per_second) begin
      sec_evt  = 1'b1;
      tick_nxt = '0;
    end

    if (sec_evt) begin
      armed_nxt = 1'b0;
      sec_nxt   = sec_r + 1'b1;
      if (sec_nxt == cfg.seconds_per_minute) begin
        sec_nxt  = '0;
        tick_nxt = '0;
        drv_nxt  = tock_nxt ? 2'b10 : 2'b01;
        tock_nxt = ~tock_nxt;
      end
    end

    if (pressed) begin
      if (hold_r != HoldMax) begin
        hold_nxt = hold_r + 1'b1;
      end
      seen_nxt = 1'b1;
      if (hold_nxt >= cfg.long_press_ticks && drv_nxt == 2'b00 &&
          tick_nxt >= cfg.pulse_width_ticks) begin
        tick_nxt = '0;
        drv_nxt  = tock_nxt ? 2'b10 : 2'b01;
        tock_nxt = ~tock_nxt;
      end
      if (drv_nxt != 2'b00 && tick_nxt >= cfg.pulse_width_ticks) begin
        drv_nxt = 2'b00;
      end
    end else if (seen_r && hold_r < cfg.long_press_ticks) begin
      seen_nxt = 1'b0;
      hold_nxt = '0;
      if (armed_nxt) begin
        tick_nxt = '0;
        drv_nxt  = tock_nxt ? 2'b10 : 2'b01;
        tock_nxt = ~tock_nxt;
      end else begin
        tick_nxt  = '0;
        sec_nxt   = '0;
        armed_nxt = 1'b1;
      end
    end else begin
      seen_nxt = 1'b0;
      hold_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      sec_r   <= '0;
      tock_r  <= 1'b0;
      drv_r   <= 2'b00;
      hold_r  <= '0;
      seen_r  <= 1'b0;
      armed_r <= 1'b0;
    end else if (step) begin
      tick_r  <= tick_nxt;
      sec_r   <= sec_nxt;
      tock_r  <= tock_nxt;
      drv_r   <= drv_nxt;
      hold_r  <= hold_nxt;
      seen_r  <= seen_nxt;
      armed_r <= armed_nxt;
    end
  end

  assign res.drive_a        = drv_nxt[0];
  assign res.drive_b        = drv_nxt[1];
  assign res.second_elapsed = sec_evt;

endmodule

FILE: rtl/slave_clock_impulse_controller.sv
// Slave clock impulse controller: one word per base tick in, one word of drive
// and second flags out. Accepts a word every cycle unless the result stalls;
// each word passes an input register and then a result register, where its
// result appears. A stalled result holds the result register; the input
// register takes one more word and then drops in_ready until the result is
// taken. Throughput is one word per cycle while the result is not stalled,
// set by the single pass of tick logic between the two registers.
module slave_clock_impulse_controller import scic_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_button_pressed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_drive_a,
  output logic                out_drive_b,
  output logic                out_second_elapsed,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    in_valid_r;
  logic    button_r;
  logic    out_valid_r;
  logic    advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  scic_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scic_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .pressed (button_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      button_r <= in_button_pressed;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_a        = res_r.drive_a;
  assign out_drive_b        = res_r.drive_b;
  assign out_second_elapsed = res_r.second_elapsed;

endmodule
